/* rtl/dfsa_pkg.sv */
// Shared types and codes for the deferred free slot allocator.
`timescale 1ns / 1ps
package dfsa_pkg;

    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 10;
    localparam int INC_W      = 13;
    localparam int CNT_CFG_W  = 11;
    localparam int ADDR_W     = 6;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CREATE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DESTROY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

    localparam logic [2:0] REG_CPU_START = 3'd0;
    localparam logic [2:0] REG_GPU_START = 3'd1;
    localparam logic [2:0] REG_INC       = 3'd2;
    localparam logic [2:0] REG_SLOTS     = 3'd3;
    localparam logic [2:0] REG_RESERVED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_DR_RD,
        S_DR_CHK,
        S_POP_RD,
        S_POP_MUL,
        S_POP_ADD,
        S_DIV,
        S_FREE_CHK,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic drain_chk;
        logic pop_rd;
        logic pop_mul;
        logic pop_add;
        logic div_init;
        logic div_step;
        logic free_chk;
        logic create_init;
        logic fill_step;
        logic destroy;
        logic set_null;
        logic set_range;
        logic set_empty;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic is_null;
        logic inc_zero;
        logic pend_empty;
        logic drain_last;
        logic free_empty;
        logic div_last;
        logic fill_go;
        logic fill_last;
    } stat_t;

    typedef struct packed {
        logic [63:0]          cpu_start;
        logic [63:0]          gpu_start;
        logic [INC_W-1:0]     inc;
        logic [CNT_CFG_W-1:0] slots;
        logic [CNT_CFG_W-1:0] reserved;
    } cfg_t;

endpackage

/* rtl/dfsa_ram.sv */
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module dfsa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/dfsa_ctrl.sv */
// Sequencer for the allocator operations.
`timescale 1ns / 1ps
module dfsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  dfsa_pkg::stat_t st,
    output dfsa_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import dfsa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.func)
                    FN_ALLOC:
                    begin
                        state_next = st.pend_empty ? S_POP_RD : S_DR_RD;
                    end
                    FN_FREE:
                    begin
                        if (st.is_null)
                        begin
                            cmd.set_null = 1'b1;
                            state_next   = S_DONE;
                        end
                        else if (st.inc_zero)
                        begin
                            cmd.set_range = 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                    FN_CREATE:
                    begin
                        cmd.create_init = 1'b1;
                        state_next      = st.fill_go ? S_FILL : S_DONE;
                    end
                    default:
                    begin
                        cmd.destroy = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_DR_RD:
            begin
                state_next = S_DR_CHK;
            end
            S_DR_CHK:
            begin
                cmd.drain_chk = 1'b1;
                state_next    = st.drain_last ? S_POP_RD : S_DR_RD;
            end
            S_POP_RD:
            begin
                if (st.free_empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_MUL;
                end
            end
            S_POP_MUL:
            begin
                cmd.pop_mul = 1'b1;
                state_next  = S_POP_ADD;
            end
            S_POP_ADD:
            begin
                cmd.pop_add = 1'b1;
                state_next  = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                cmd.free_chk = 1'b1;
                state_next   = S_DONE;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done |=> !busy;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("busy after result beat");

    property p_load_idle;
        @(posedge clk) disable iff (!rst_n) cmd.load |-> !busy;
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("load while busy");

    property p_div_free;
        @(posedge clk) disable iff (!rst_n) cmd.div_step |-> st.func == FN_FREE;
    endproperty
    a_div_free: assert property (p_div_free) else $error("divide outside free");

endmodule

/* rtl/dfsa_dp.sv */
// Datapath: free stack, pending list, divider and handle arithmetic.
`timescale 1ns / 1ps
module dfsa_dp #(
    parameter int HEAP_SLOTS    = 1024,
    parameter int PENDING_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dfsa_pkg::cmd_t                  cmd,
    output dfsa_pkg::stat_t                 st,
    input  dfsa_pkg::cfg_t                  cfg,
    input  logic [dfsa_pkg::FUNC_W-1:0]     func,
    input  logic [63:0]                     cpu_handle,
    input  logic [63:0]                     gpu_handle,
    input  logic [63:0]                     fence,
    output logic [63:0]                     cpu_handle_out,
    output logic [63:0]                     gpu_handle_out,
    output logic [dfsa_pkg::SLOT_OUT_W-1:0] slot_out,
    output logic [dfsa_pkg::STATUS_W-1:0]   status
);
    import dfsa_pkg::*;

    localparam int SW  = $clog2(HEAP_SLOTS);
    localparam int CW  = $clog2(HEAP_SLOTS + 1);
    localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PW  = $clog2(PENDING_DEPTH + 1);
    localparam int PEW = 64 + SW;

    logic [FUNC_W-1:0]     func_reg;
    logic [63:0]           cpu_in_reg;
    logic                  null_reg;
    logic [63:0]           fence_reg;
    logic [CW-1:0]         fcount_reg;
    logic [PW-1:0]         pcount_reg;
    logic [PW-1:0]         i_reg;
    logic [PW-1:0]         keep_reg;
    logic [CW-1:0]         fill_reg;
    logic [63:0]           dq_reg;
    logic [INC_W:0]        rem_reg;
    logic [6:0]            step_reg;
    logic [SW+INC_W-1:0]   prod_reg;
    logic [SW-1:0]         pop_slot_reg;
    logic [63:0]           cpu_out_reg;
    logic [63:0]           gpu_out_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [CW-1:0]  lim;
    logic [PW-1:0]  i_inc;
    logic [INC_W:0] trial;
    logic           ge;
    logic           fence_met;
    logic           can_push;

    logic           stk_we;
    logic [SW-1:0]  stk_waddr;
    logic [SW-1:0]  stk_wdata;
    logic [SW-1:0]  stk_raddr;
    logic [SW-1:0]  stk_rdata;

    logic           pen_we;
    logic [PIW-1:0] pen_waddr;
    logic [PEW-1:0] pen_wdata;
    logic [PEW-1:0] pen_rdata;
    logic [63:0]    pen_fence;
    logic [SW-1:0]  pen_slot;

    assign lim = (32'(cfg.slots) > HEAP_SLOTS) ? CW'(HEAP_SLOTS) : CW'(cfg.slots);
    assign i_inc = i_reg + PW'(1);
    assign pen_fence = pen_rdata[PEW-1:SW];
    assign pen_slot  = pen_rdata[SW-1:0];
    assign fence_met = (fence_reg >= pen_fence);
    assign can_push  = (32'(fcount_reg) < HEAP_SLOTS);

    // one restoring divide step: shift in the next dividend bit
    assign trial = {rem_reg[INC_W-1:0], dq_reg[63]};
    assign ge    = (trial >= {1'b0, cfg.inc});

    always_comb
    begin
        st.func       = func_reg;
        st.is_null    = null_reg;
        st.inc_zero   = (cfg.inc == '0);
        st.pend_empty = (pcount_reg == '0);
        st.drain_last = (i_inc == pcount_reg);
        st.free_empty = (fcount_reg == '0);
        st.div_last   = (step_reg == 7'd63);
        st.fill_go    = (32'(lim) > 32'(cfg.reserved));
        st.fill_last  = (32'(fill_reg) - 32'd1 <= 32'(cfg.reserved));
    end

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = fcount_reg[SW-1:0];
        stk_wdata = pen_slot;
        if (cmd.drain_chk && fence_met && can_push)
        begin
            stk_we = 1'b1;
        end
        else if (cmd.fill_step && can_push)
        begin
            stk_we    = 1'b1;
            stk_wdata = SW'(fill_reg - CW'(1));
        end
        stk_raddr = SW'(fcount_reg - CW'(1));
    end

    always_comb
    begin
        pen_we    = 1'b0;
        pen_waddr = keep_reg[PIW-1:0];
        pen_wdata = pen_rdata;
        if (cmd.drain_chk && !fence_met)
        begin
            pen_we = 1'b1;
        end
        else if (cmd.free_chk && dq_reg < 64'(lim) && 32'(pcount_reg) < PENDING_DEPTH)
        begin
            pen_we    = 1'b1;
            pen_waddr = pcount_reg[PIW-1:0];
            pen_wdata = {fence_reg, dq_reg[SW-1:0]};
        end
    end

    dfsa_ram #(.W(SW), .DEPTH(HEAP_SLOTS)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    dfsa_ram #(.W(PEW), .DEPTH(PENDING_DEPTH)) u_pending (
        .clk   (clk),
        .we    (pen_we),
        .waddr (pen_waddr),
        .wdata (pen_wdata),
        .raddr (i_reg[PIW-1:0]),
        .rdata (pen_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= '0;
            pcount_reg <= '0;
            i_reg      <= '0;
            keep_reg   <= '0;
            step_reg   <= '0;
            func_reg   <= FN_ALLOC;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg   <= func;
                i_reg      <= '0;
                keep_reg   <= '0;
                status_reg <= ST_OK;
            end
            if (cmd.drain_chk)
            begin
                i_reg <= i_inc;
                if (fence_met)
                begin
                    if (can_push)
                    begin
                        fcount_reg <= fcount_reg + CW'(1);
                    end
                    if (st.drain_last)
                    begin
                        pcount_reg <= keep_reg;
                    end
                end
                else
                begin
                    keep_reg <= keep_reg + PW'(1);
                    if (st.drain_last)
                    begin
                        pcount_reg <= keep_reg + PW'(1);
                    end
                end
            end
            if (cmd.pop_rd)
            begin
                fcount_reg <= fcount_reg - CW'(1);
            end
            if (cmd.div_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 7'd1;
            end
            if (cmd.free_chk)
            begin
                if (dq_reg >= 64'(lim))
                begin
                    status_reg <= ST_RANGE;
                end
                else if (32'(pcount_reg) >= PENDING_DEPTH)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    pcount_reg <= pcount_reg + PW'(1);
                end
            end
            if (cmd.create_init)
            begin
                pcount_reg <= '0;
                fcount_reg <= '0;
            end
            if (cmd.fill_step && can_push)
            begin
                fcount_reg <= fcount_reg + CW'(1);
            end
            if (cmd.destroy)
            begin
                fcount_reg <= '0;
            end
            if (cmd.set_null)
            begin
                status_reg <= ST_NULL;
            end
            if (cmd.set_range)
            begin
                status_reg <= ST_RANGE;
            end
            if (cmd.set_empty)
            begin
                status_reg <= ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cpu_in_reg  <= cpu_handle;
            null_reg    <= (cpu_handle == '0) || (gpu_handle == '0);
            fence_reg   <= fence;
            cpu_out_reg <= '0;
            gpu_out_reg <= '0;
            slot_reg    <= '0;
        end
        if (cmd.div_init)
        begin
            dq_reg  <= cpu_in_reg - cfg.cpu_start;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[62:0], ge};
            rem_reg <= ge ? (trial - {1'b0, cfg.inc}) : trial;
        end
        if (cmd.free_chk && dq_reg < 64'(lim))
        begin
            slot_reg <= SLOT_OUT_W'(dq_reg);
        end
        if (cmd.create_init)
        begin
            fill_reg <= lim;
        end
        else if (cmd.fill_step)
        begin
            fill_reg <= fill_reg - CW'(1);
        end
        if (cmd.pop_mul)
        begin
            prod_reg     <= (SW+INC_W)'(stk_rdata) * (SW+INC_W)'(cfg.inc);
            pop_slot_reg <= stk_rdata;
        end
        if (cmd.pop_add)
        begin
            cpu_out_reg <= cfg.cpu_start + 64'(prod_reg);
            gpu_out_reg <= cfg.gpu_start + 64'(prod_reg);
            slot_reg    <= SLOT_OUT_W'(pop_slot_reg);
        end
    end

    assign cpu_handle_out = cpu_out_reg;
    assign gpu_handle_out = gpu_out_reg;
    assign slot_out       = slot_reg;
    assign status         = status_reg;

    property p_fcount_bound;
        @(posedge clk) disable iff (!rst_n) 32'(fcount_reg) <= HEAP_SLOTS;
    endproperty
    a_fcount_bound: assert property (p_fcount_bound) else $error("free count overflow");

    property p_pcount_bound;
        @(posedge clk) disable iff (!rst_n) 32'(pcount_reg) <= PENDING_DEPTH;
    endproperty
    a_pcount_bound: assert property (p_pcount_bound) else $error("pending count overflow");

    property p_keep_behind;
        @(posedge clk) disable iff (!rst_n) keep_reg <= i_reg;
    endproperty
    a_keep_behind: assert property (p_keep_behind) else $error("compaction ahead of scan");

endmodule

/* rtl/deferred_free_slot_allocator_top.sv */
// From the start beat to the done beat: alloc scans the pending list (if not empty), then pops
// the stack; free divides (not for a null handle or zero increment); create fills the stack;
// destroy empties it. One command at a time; throughput is set by the pending-list scan (a read
// and a check per entry on the pending RAM port), the bit-serial 64-step divider and the
// one-slot-per-cycle stack fill. The result beat is shown on done for one cycle; the receiver
// cannot stall. Reset (rst_n, async, low) empties stack and pending list, loads defaults.
`timescale 1ns / 1ps
module deferred_free_slot_allocator_top #(
    parameter int HEAP_SLOTS    = 1024,
    parameter int PENDING_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dfsa_pkg::FUNC_W-1:0]     func,
    input  logic [63:0]                     cpu_handle,
    input  logic [63:0]                     gpu_handle,
    input  logic [63:0]                     fence,
    output logic                            done,
    output logic [63:0]                     cpu_handle_out,
    output logic [63:0]                     gpu_handle_out,
    output logic [dfsa_pkg::SLOT_OUT_W-1:0] slot_out,
    output logic [dfsa_pkg::STATUS_W-1:0]   status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dfsa_pkg::ADDR_W-1:0]     paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    import dfsa_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    stat_t      st;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpu_start <= '0;
            cfg_reg.gpu_start <= '0;
            cfg_reg.inc       <= INC_W'(32);
            cfg_reg.slots     <= CNT_CFG_W'(1024);
            cfg_reg.reserved  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CPU_START: cfg_reg.cpu_start <= pwdata;
                REG_GPU_START: cfg_reg.gpu_start <= pwdata;
                REG_INC:       cfg_reg.inc       <= pwdata[INC_W-1:0];
                REG_SLOTS:     cfg_reg.slots     <= pwdata[CNT_CFG_W-1:0];
                REG_RESERVED:  cfg_reg.reserved  <= pwdata[CNT_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CPU_START: prdata = cfg_reg.cpu_start;
            REG_GPU_START: prdata = cfg_reg.gpu_start;
            REG_INC:       prdata = 64'(cfg_reg.inc);
            REG_SLOTS:     prdata = 64'(cfg_reg.slots);
            REG_RESERVED:  prdata = 64'(cfg_reg.reserved);
            default:       prdata = '0;
        endcase
    end

    dfsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dfsa_dp #(
        .HEAP_SLOTS    (HEAP_SLOTS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg            (cfg_reg),
        .func           (func),
        .cpu_handle     (cpu_handle),
        .gpu_handle     (gpu_handle),
        .fence          (fence),
        .cpu_handle_out (cpu_handle_out),
        .gpu_handle_out (gpu_handle_out),
        .slot_out       (slot_out),
        .status         (status)
    );

endmodule
